[rtl/swm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and control types for the sliding window maximum block.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int WINDOW_MAX_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int CFG_WIDTH        = 7;
    localparam int WINDOW_RESET     = 1;

    typedef struct packed {
        logic load;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic en;
        logic vld;
    } stage_ctrl_t;

endpackage

[rtl/swm_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_cell
// One queue cell: holds the sample of a fixed age and whether it is still
// queued, and hands both to the next older cell on every request.
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
    parameter int WIN_W        = 7,
    parameter int AGE          = 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  swm_pkg::cell_ctrl_t            ctrl,
    input  logic [WIN_W-1:0]               win,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           up_keep,
    input  logic signed [SAMPLE_WIDTH-1:0] up_value,
    output logic                           keep,
    output logic signed [SAMPLE_WIDTH-1:0] value
);

    localparam logic [WIN_W-1:0] AGE_V = WIN_W'(AGE);

    logic                           live_reg;
    logic                           live_next;
    logic signed [SAMPLE_WIDTH-1:0] value_reg;
    logic signed [SAMPLE_WIDTH-1:0] value_next;

    // drop on new sequence, on expiry, or when a larger sample arrives
    always_comb begin
        keep = live_reg && !ctrl.clear && (AGE_V < win) && !(value_reg < sample);
    end

    always_comb begin
        live_next  = live_reg;
        value_next = value_reg;
        if (ctrl.load) begin
            live_next  = up_keep;
            value_next = up_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg <= 1'b0;
        end else begin
            live_reg <= live_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

[rtl/swm_max_tree.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_max_tree
// Pipelined binary maximum tree, one register level per tree level.
// ----------------------------------------------------------------------------
module swm_max_tree #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
    parameter int LEAVES       = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  swm_pkg::stage_ctrl_t           ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] leaf [LEAVES],
    output logic                           out_valid,
    output logic signed [SAMPLE_WIDTH-1:0] out_max
);

    localparam int LEVELS = $clog2(LEAVES);

    logic signed [SAMPLE_WIDTH-1:0] node_reg [1:LEAVES-1];
    logic [LEVELS-1:0]              vld_reg;
    logic [LEVELS-1:0]              vld_next;

    genvar k;
    generate
        for (k = 1; k < LEAVES; k++) begin : g_node
            logic signed [SAMPLE_WIDTH-1:0] lhs;
            logic signed [SAMPLE_WIDTH-1:0] rhs;
            if (2 * k >= LEAVES) begin : g_leaf
                assign lhs = leaf[2 * k - LEAVES];
                assign rhs = leaf[2 * k + 1 - LEAVES];
            end else begin : g_inner
                assign lhs = node_reg[2 * k];
                assign rhs = node_reg[2 * k + 1];
            end
            always_ff @(posedge aclk) begin
                if (ctrl.en) begin
                    node_reg[k] <= (rhs > lhs) ? rhs : lhs;
                end
            end
        end
    endgenerate

    always_comb begin
        vld_next = vld_reg;
        if (ctrl.en) begin
            vld_next = LEVELS'({vld_reg, ctrl.vld});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign out_valid = vld_reg[LEVELS-1];
    assign out_max   = node_reg[1];

endmodule

[rtl/sliding_window_maximum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_maximum
// Running maximum of the last window_size signed samples.
// ----------------------------------------------------------------------------
// Takes one sample per clock. Samples travel down a row of WINDOW_MAX-1 cells,
// one cell per sample age; each cell keeps its sample queued until it expires
// or a strictly larger sample arrives, so the live cells form a non-increasing
// queue. The maximum of the live cells and the new sample is taken by a binary
// tree with one register level per tree level. A result follows every sample
// once window_size samples of the current sequence have arrived; a set start
// flag begins a new sequence. A stall on the result side holds the whole
// pipeline. The user must write window_size only while the block is idle; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module sliding_window_maximum #(
    parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
    localparam int DATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wen,
    input  logic [swm_pkg::CFG_WIDTH-1:0]  cfg_wdata,   // window_size
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [DATA_W-1:0]              s_tdata,     // sample
    input  logic                           s_tuser,     // start_req
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [DATA_W-1:0]              m_tdata      // window_max
);

    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W  = (CNT_W > swm_pkg::CFG_WIDTH) ? CNT_W : swm_pkg::CFG_WIDTH;
    localparam int LEAVES = (WINDOW_MAX < 2) ? 2 : (1 << $clog2(WINDOW_MAX));

    logic [swm_pkg::CFG_WIDTH-1:0]  win_size_reg;
    logic [swm_pkg::CFG_WIDTH-1:0]  win_size_next;
    logic [CNT_W-1:0]               fill_reg;
    logic [CNT_W-1:0]               fill_next;
    logic [CNT_W-1:0]               fill_base;
    logic [CMP_W-1:0]               win_ext;
    logic [CNT_W-1:0]               win_eff;
    logic                           advance;
    logic                           accept;
    logic                           produce;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic signed [SAMPLE_WIDTH-1:0] max_out;
    logic                           chain_keep  [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] chain_value [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] leaf        [LEAVES];
    swm_pkg::cell_ctrl_t            cell_ctrl;
    swm_pkg::stage_ctrl_t           tree_ctrl;

    assign sample   = signed'(s_tdata[SAMPLE_WIDTH-1:0]);
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    // clamp window size to 1..WINDOW_MAX
    always_comb begin
        win_ext = CMP_W'(win_size_reg);
        if (win_ext == '0) begin
            win_eff = CNT_W'(1);
        end else if (win_ext > CMP_W'(WINDOW_MAX)) begin
            win_eff = CNT_W'(WINDOW_MAX);
        end else begin
            win_eff = win_ext[CNT_W-1:0];
        end
    end

    always_comb begin
        fill_base = s_tuser ? '0 : fill_reg;
        if (fill_base == CNT_W'(WINDOW_MAX)) begin
            fill_next = fill_base;
        end else begin
            fill_next = fill_base + CNT_W'(1);
        end
        produce = (fill_next >= win_eff);
    end

    always_comb begin
        win_size_next = win_size_reg;
        if (cfg_wen) begin
            win_size_next = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_size_reg <= swm_pkg::CFG_WIDTH'(swm_pkg::WINDOW_RESET);
            fill_reg     <= '0;
        end else begin
            win_size_reg <= win_size_next;
            if (accept) begin
                fill_reg <= fill_next;
            end
        end
    end

    assign cell_ctrl.load  = accept;
    assign cell_ctrl.clear = s_tuser;

    assign chain_keep[0]  = 1'b1;
    assign chain_value[0] = sample;

    genvar j;
    generate
        for (j = 0; j < WINDOW_MAX - 1; j++) begin : g_cell
            swm_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .WIN_W        (CNT_W),
                .AGE          (j + 1)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (cell_ctrl),
                .win      (win_eff),
                .sample   (sample),
                .up_keep  (chain_keep[j]),
                .up_value (chain_value[j]),
                .keep     (chain_keep[j + 1]),
                .value    (chain_value[j + 1])
            );
        end
        for (j = 0; j < LEAVES; j++) begin : g_leaf
            if (j < WINDOW_MAX) begin : g_used
                assign leaf[j] = chain_keep[j] ? chain_value[j] : sample;
            end else begin : g_pad
                assign leaf[j] = sample;
            end
        end
    endgenerate

    assign tree_ctrl.en  = advance;
    assign tree_ctrl.vld = accept && produce;

    swm_max_tree #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .LEAVES       (LEAVES)
    ) u_tree (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (tree_ctrl),
        .leaf      (leaf),
        .out_valid (m_tvalid),
        .out_max   (max_out)
    );

    assign m_tdata = DATA_W'(unsigned'(max_out));

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(WINDOW_MAX))
        else $error("fill count above window capacity");

    a_start_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tuser |=> fill_reg == CNT_W'(1))
        else $error("start request did not restart fill count");

    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(fill_reg))
        else $error("fill count moved without a request");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while result stage empty");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level check of the sliding window maximum block.
// ----------------------------------------------------------------------------
// Sample requests from a queue are driven in random bursts. The result side
// stalls on a pattern of its own. Each accepted request runs through a
// non-increasing queue model that produces the expected window maximum.
// The window size changes between phases, including values out of range and
// changes in the middle of a sequence. Phases use ramps, flat runs, extremes
// and noise.
// ----------------------------------------------------------------------------
module tb;

    localparam int WMAX          = swm_pkg::WINDOW_MAX_DEF;
    localparam int SW            = swm_pkg::SAMPLE_WIDTH_DEF;
    localparam int CW            = swm_pkg::CFG_WIDTH;
    localparam int DW            = ((SW + 7) / 8) * 8;
    localparam int PW            = $clog2(WMAX);
    localparam int SETTLE_CYCLES = 16;
    localparam int REQ_DEPTH     = 2048;

    typedef struct packed {
        logic                 start;
        logic signed [SW-1:0] sample;
    } sample_req_t;

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          cfg_wen   = 1'b0;
    logic [CW-1:0] cfg_wdata = '0;
    logic          s_tvalid  = 1'b0;
    logic          s_tready;
    logic [DW-1:0] s_tdata   = '0;
    logic          s_tuser   = 1'b0;
    logic          m_tvalid;
    logic          m_tready  = 1'b0;
    logic [DW-1:0] m_tdata;

    sliding_window_maximum uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sample_req_t          pending_reqs[REQ_DEPTH];
    int                   pend_wr = 0;
    int                   pend_rd = 0;
    logic signed [SW-1:0] expected_max[REQ_DEPTH];
    int                   exp_wr  = 0;
    int                   exp_rd  = 0;

    // window model state
    logic signed [SW-1:0] dq_val[WMAX];
    logic [PW-1:0]        dq_pos[WMAX];
    int                   dq_count   = 0;
    logic [PW-1:0]        next_pos   = '0;
    int                   seen_count = 0;
    logic [CW-1:0]        window_reg = CW'(swm_pkg::WINDOW_RESET);

    int   failures     = 0;
    int   reqs_taken   = 0;
    int   maxima_seen  = 0;
    int   window_sets  = 0;
    logic req_taken    = 1'b0;
    int   burst_left   = 8;
    int   gap_left     = 0;
    int   ready_mode   = 0;
    int   ready_cycle  = 0;

    function automatic void window_step(input logic signed [SW-1:0] smp, input logic start,
                                        output bit has_max,
                                        output logic signed [SW-1:0] max_val);
        int            win;
        int            age;
        logic [PW-1:0] p;
        logic [PW-1:0] pos_diff;
        win = int'(window_reg);
        if (win == 0) win = 1;
        if (win > WMAX) win = WMAX;
        if (start) begin
            dq_count   = 0;
            seen_count = 0;
            next_pos   = '0;
        end
        p = next_pos;
        // expire old head entries; a matching position means a full window of age
        while (dq_count > 0) begin
            pos_diff = p - dq_pos[0];
            age      = int'(pos_diff);
            if (age == 0) age = WMAX;
            if (age < win) break;
            for (int i = 0; i < dq_count - 1; i++) begin
                dq_val[i] = dq_val[i+1];
                dq_pos[i] = dq_pos[i+1];
            end
            dq_count--;
        end
        while (dq_count > 0 && dq_val[dq_count-1] < smp) dq_count--;
        if (dq_count < WMAX) begin
            dq_val[dq_count] = smp;
            dq_pos[dq_count] = p;
            dq_count++;
        end
        next_pos = p + 1'b1;
        if (seen_count < WMAX) seen_count++;
        has_max = (seen_count >= win);
        max_val = dq_val[0];
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= 10) $display("ERROR %0t: %s", $time, msg);
    endtask

    // take requests, predict, check results
    always @(posedge aclk) begin
        sample_req_t          req;
        bit                   has_max;
        logic signed [SW-1:0] max_val;
        logic signed [SW-1:0] want;
        req_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (cfg_wen) window_reg = cfg_wdata;
            if (s_tvalid && s_tready) begin
                req = pending_reqs[pend_rd];
                pend_rd++;
                reqs_taken++;
                window_step(req.sample, req.start, has_max, max_val);
                if (has_max) begin
                    expected_max[exp_wr] = max_val;
                    exp_wr++;
                end
            end
            if (m_tvalid && m_tready) begin
                maxima_seen++;
                if (exp_rd >= exp_wr) begin
                    note_failure($sformatf("window_max %0d with nothing pending",
                                           $signed(m_tdata[SW-1:0])));
                end else begin
                    want = expected_max[exp_rd];
                    exp_rd++;
                    if (m_tdata[SW-1:0] !== want)
                        note_failure($sformatf("window_max expected %0d got %0d", want,
                                               $signed(m_tdata[SW-1:0])));
                end
            end
        end
    end

    // sender: bursts with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_taken) begin
            if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left--;
            end else if (pend_rd < pend_wr) begin
                s_tvalid <= 1'b1;
                s_tdata  <= DW'(pending_reqs[pend_rd].sample);
                s_tuser  <= pending_reqs[pend_rd].start;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern chosen at random from four modes
    always @(negedge aclk) begin
        ready_cycle++;
        if (ready_cycle % 256 == 0) ready_mode = $urandom_range(0, 3);
        case (ready_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
                m_tready <= (ready_cycle % 8 < 5);
            end
            default: begin
                m_tready <= ($urandom_range(0, 9) < 3);
            end
        endcase
    end

    task automatic add_req(input logic signed [SW-1:0] smp, input logic start);
        sample_req_t req;
        req.sample = smp;
        req.start  = start;
        pending_reqs[pend_wr] = req;
        pend_wr++;
    endtask

    task automatic drain();
        int n;
        n = 0;
        while (pend_rd < pend_wr || exp_rd < exp_wr || s_tvalid)
            @(posedge aclk);
        // let requests with no result leave the pipeline
        while (n < SETTLE_CYCLES) begin
            @(posedge aclk);
            if (m_tready) n++;
        end
    endtask

    task automatic set_window(input int w);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= CW'(w);
        @(negedge aclk);
        cfg_wen   <= 1'b0;
        window_sets++;
    endtask

    task automatic add_phase(input int count, input int start_odds);
        int                   left;
        int                   run;
        int                   kind;
        int                   step;
        logic signed [SW-1:0] base;
        logic signed [SW-1:0] v;
        logic                 st;
        left = count;
        st   = 1'($urandom_range(0, 1));
        while (left > 0) begin
            kind = $urandom_range(0, 5);
            run  = (kind == 2) ? $urandom_range(20, 130) : $urandom_range(4, 80);
            if (run > left) run = left;
            base = SW'($urandom);
            step = $urandom_range(0, 3);
            for (int i = 0; i < run; i++) begin
                case (kind)
                    0: v = SW'($urandom);
                    1: v = SW'($urandom_range(0, 4)) - SW'(2);
                    2: v = base - SW'(i * step);
                    3: v = base + SW'(i * step);
                    4: begin
                        case ($urandom_range(0, 3))
                            0: v = {1'b0, {(SW-1){1'b1}}};
                            1: v = {1'b1, {(SW-1){1'b0}}};
                            2: v = '0;
                            default: v = '1;
                        endcase
                    end
                    default: v = base;
                endcase
                add_req(v, st);
                st = ($urandom_range(1, start_odds) == 1);
            end
            left -= run;
        end
    endtask

    localparam int N_PHASES = 10;
    int phase_window[N_PHASES] = '{64, 0, 127, 65, 5, 2, 33, 63, 1, 17};
    int phase_odds[N_PHASES]   = '{300, 40, 200, 150, 8, 20, 100, 300, 30, 60};

    initial begin
        logic signed [SW-1:0] pos_max;
        logic signed [SW-1:0] neg_max;
        pos_max = {1'b0, {(SW-1){1'b1}}};
        neg_max = {1'b1, {(SW-1){1'b0}}};
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset window of one: extremes pass straight through
        add_req(pos_max, 1'b1);
        add_req(neg_max, 1'b0);
        add_req('0, 1'b0);
        add_req('1, 1'b0);
        add_req(SW'(1), 1'b0);
        drain();

        // duplicates, larger sample flush, decreasing run, restart mid-sequence
        set_window(4);
        add_req(SW'(5), 1'b1);
        add_req(SW'(5), 1'b0);
        add_req(SW'(5), 1'b0);
        add_req(SW'(3), 1'b0);
        add_req(SW'(9), 1'b0);
        add_req(neg_max, 1'b0);
        add_req(pos_max, 1'b0);
        add_req(SW'(2), 1'b0);
        add_req(SW'(1), 1'b0);
        add_req('0, 1'b0);
        add_req('1, 1'b0);
        add_req(-SW'(2), 1'b0);
        add_req(SW'(6), 1'b1);
        add_req(SW'(7), 1'b0);
        add_req(SW'(8), 1'b0);
        add_req(SW'(9), 1'b0);
        drain();

        // shrink window without restarting
        set_window(2);
        add_req(SW'(3), 1'b0);
        add_req(SW'(2), 1'b0);
        add_req(SW'(1), 1'b0);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            set_window(phase_window[ph]);
            add_phase(140, phase_odds[ph]);
            drain();
        end

        $display("Ran %0d sample requests across %0d window settings;", reqs_taken,
                 window_sets + 1);
        $display("checked %0d window maxima, %0d mismatches.", maxima_seen, failures);
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", exp_wr - exp_rd);
        $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/swm_max_tree.sv
rtl/sliding_window_maximum.sv
dv/tb.sv
